[hw/rtl/stereo_crossfeed_mix_limiter_assert.svh]
// ----------------------------------------------------------------------------
// stereo crossfeed mix limiter assertion macros
// concurrent assertion wrappers clocked on clk with asynchronous reset rst_n
// ----------------------------------------------------------------------------
`ifndef STEREO_CROSSFEED_MIX_LIMITER_ASSERT_SVH
`define STEREO_CROSSFEED_MIX_LIMITER_ASSERT_SVH

// same-cycle implication
`define SCF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SCF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/scf_pkg.sv]
// ----------------------------------------------------------------------------
// scf_pkg
// shared constants, register codes and control structs of the crossfeed block
// ----------------------------------------------------------------------------
package scf_pkg;

    localparam int HISTORY_DEPTH_DEF = 128;

    // limiter constants, gain in Q1.24, samples in Q8
    localparam logic [24:0] UNITY_Q24     = 25'd16777216;
    localparam logic [24:0] RECOVERY_Q24  = 25'd16775538;
    localparam logic [27:0] FULL_SCALE_Q8 = 28'd8388608;
    localparam int          DIV_STEPS     = 12;

    // register reset values
    localparam logic [14:0] STRENGTH_RST = 15'd0;
    localparam logic [15:0] ALPHA_RST    = 16'd5738;
    localparam logic [14:0] DELAY_RST    = 15'd0;
    localparam logic [23:0] REL_RST      = 24'd16770227;
    localparam logic [17:0] MIX_ONE_RST  = 18'd65536;
    localparam logic [17:0] MIX_ZERO_RST = 18'd0;

    typedef enum logic [2:0] {
        REG_STRENGTH = 3'd0,
        REG_ALPHA    = 3'd1,
        REG_DELAY    = 3'd2,
        REG_RELEASE  = 3'd3,
        REG_MIX_LL   = 3'd4,
        REG_MIX_LR   = 3'd5,
        REG_MIX_RL   = 3'd6,
        REG_MIX_RR   = 3'd7
    } scf_reg_t;

    // step strobes from the sequencer
    typedef struct packed {
        logic lp;
        logic wr;
        logic ra;
        logic rb;
        logic ip1;
        logic ip2;
        logic xf;
        logic mx;
        logic m1;
        logic m2;
        logic pk;
        logic dv;
        logic g1;
        logic g2;
        logic o1;
        logic o2;
    } scf_ctl_t;

    // limiter status back to the sequencer
    typedef struct packed {
        logic div_need;
        logic div_done;
        logic out_stall;
    } scf_stat_t;

endpackage

[hw/rtl/scf_if.sv]
// ----------------------------------------------------------------------------
// scf channel interfaces
// frame input, result output and configuration write channels
// ----------------------------------------------------------------------------
interface scf_frame_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface scf_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               limiting;

    modport source (output valid, output left_out, output right_out, output limiting,
                    input ready);
    modport sink (input valid, input left_out, input right_out, input limiting,
                  output ready);
endinterface

interface scf_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/scf_ram.sv]
// ----------------------------------------------------------------------------
// scf_ram
// generic single write, single read RAM with registered read data
// ----------------------------------------------------------------------------
module scf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/scf_lane.sv]
// ----------------------------------------------------------------------------
// scf_lane
// one channel: lowpass, history line, fractional delay and crossfeed add
// ----------------------------------------------------------------------------
module scf_lane
    import scf_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    localparam int AW = $clog2(HISTORY_DEPTH)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  scf_ctl_t           ctl,
    input  logic signed [15:0] pcm,
    input  logic [15:0]        alpha,
    input  logic [7:0]         frac,
    input  logic [14:0]        strength,
    input  logic [AW-1:0]      wr_addr,
    input  logic [AW-1:0]      tap_a,
    input  logic [AW-1:0]      tap_b,
    input  logic               ok_a,
    input  logic               ok_b,
    input  logic signed [23:0] opp_delayed,
    output logic signed [23:0] delayed,
    output logic signed [24:0] mixed
);

    logic signed [23:0] x;
    logic signed [24:0] diff;
    logic signed [41:0] lp_prod_reg;
    logic signed [41:0] lp_rnd;
    logic signed [23:0] low_reg;
    logic signed [23:0] low_next;
    logic [AW-1:0]      raddr;
    logic [23:0]        rdata;
    logic               ok_reg;
    logic signed [23:0] ha_reg;
    logic signed [23:0] hb;
    logic signed [33:0] ip_prod_reg;
    logic signed [33:0] ip_rnd;
    logic signed [23:0] delayed_reg;
    logic signed [39:0] xf_prod_reg;
    logic signed [39:0] xf_rnd;
    logic signed [24:0] mixed_reg;

    assign x    = {pcm, 8'd0};
    assign diff = 25'(x) - 25'(low_reg);

    // lowpass update with round half up
    assign lp_rnd   = lp_prod_reg + 42'sd32768;
    assign low_next = 24'(26'(low_reg) + $signed(lp_rnd[41:16]));

    // history line
    assign raddr = ctl.rb ? tap_b : tap_a;

    scf_ram #(
        .WIDTH(24),
        .DEPTH(HISTORY_DEPTH)
    ) u_hist (
        .clk  (clk),
        .we   (ctl.wr),
        .waddr(wr_addr),
        .wdata(low_next),
        .raddr(raddr),
        .rdata(rdata)
    );

    // entries never written read as zero
    assign hb     = ok_reg ? $signed(rdata) : 24'sd0;
    assign ip_rnd = ip_prod_reg + 34'sd128;
    assign xf_rnd = xf_prod_reg + 40'sd32768;

    // lowpass state and delayed sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg     <= '0;
            delayed_reg <= '0;
        end
        else
        begin
            if (ctl.wr)
            begin
                low_reg <= low_next;
            end
            if (ctl.ip2)
            begin
                delayed_reg <= 24'(26'(ha_reg) + $signed(ip_rnd[33:8]));
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        ok_reg <= ctl.rb ? ok_b : ok_a;
        if (ctl.lp)
        begin
            lp_prod_reg <= 42'($signed({1'b0, alpha})) * 42'(diff);
        end
        if (ctl.rb)
        begin
            ha_reg <= hb;
        end
        if (ctl.ip1)
        begin
            ip_prod_reg <= 34'($signed({1'b0, frac})) * 34'(25'(hb) - 25'(ha_reg));
        end
        if (ctl.xf)
        begin
            xf_prod_reg <= 40'($signed({1'b0, strength})) * 40'(opp_delayed);
        end
        if (ctl.mx)
        begin
            mixed_reg <= 25'(x) + 25'($signed(xf_rnd[39:16]));
        end
    end

    assign delayed = delayed_reg;
    assign mixed   = mixed_reg;

endmodule

[hw/rtl/scf_limiter.sv]
// ----------------------------------------------------------------------------
// scf_limiter
// merge stage: output matrix, peak detect, gain divider, release and clamp
// ----------------------------------------------------------------------------
module scf_limiter
    import scf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  scf_ctl_t           ctl,
    input  logic signed [24:0] mixed_left,
    input  logic signed [24:0] mixed_right,
    input  logic signed [17:0] mix_ll,
    input  logic signed [17:0] mix_lr,
    input  logic signed [17:0] mix_rl,
    input  logic signed [17:0] mix_rr,
    input  logic [23:0]        rel_coef,
    input  logic               out_ready,
    output logic               out_valid,
    output logic signed [15:0] left_out,
    output logic signed [15:0] right_out,
    output logic               limiting,
    output scf_stat_t          stat
);

    localparam int CW = $clog2(DIV_STEPS);

    logic signed [42:0] p_ll_reg, p_lr_reg, p_rl_reg, p_rr_reg;
    logic signed [43:0] sum_l, sum_r;
    logic signed [27:0] ol_reg, or_reg;
    logic [27:0]        mag_l, mag_r, peak_next, peak_reg;
    logic               need_reg;
    logic [28:0]        rem_reg, rem_next;
    logic [23:0]        q_reg, q_next;
    logic [CW-1:0]      cnt_reg;
    logic [24:0]        target;
    logic [24:0]        target_reg;
    logic               lower_reg;
    logic signed [49:0] g_prod_reg;
    logic signed [49:0] g_rnd;
    logic signed [25:0] g_sum;
    logic [24:0]        gain_next;
    logic [24:0]        gain_reg;
    logic signed [53:0] y_prod_l_reg, y_prod_r_reg;
    logic signed [53:0] y_rnd_l, y_rnd_r;
    logic signed [21:0] y_l, y_r;
    logic signed [15:0] clamp_l, clamp_r;
    logic               out_valid_reg;
    logic signed [15:0] left_reg, right_reg;
    logic               limiting_reg;

    // matrix sums with rounding
    assign sum_l = 44'(p_ll_reg) + 44'(p_lr_reg) + 44'sd32768;
    assign sum_r = 44'(p_rl_reg) + 44'(p_rr_reg) + 44'sd32768;

    // peak of the two magnitudes
    assign mag_l     = ol_reg[27] ? 28'(-ol_reg) : 28'(ol_reg);
    assign mag_r     = or_reg[27] ? 28'(-or_reg) : 28'(or_reg);
    assign peak_next = (mag_l > mag_r) ? mag_l : mag_r;

    // two restoring division steps per cycle for 2^47 / peak
    always_comb
    begin
        rem_next = rem_reg;
        q_next   = q_reg;
        for (int i = 0; i < 2; i++)
        begin
            rem_next = {rem_next[27:0], 1'b0};
            if (rem_next >= {1'b0, peak_reg})
            begin
                rem_next = rem_next - {1'b0, peak_reg};
                q_next   = {q_next[22:0], 1'b1};
            end
            else
            begin
                q_next = {q_next[22:0], 1'b0};
            end
        end
    end

    assign target = need_reg ? {1'b0, q_reg} : UNITY_Q24;

    // release toward target and snap back to unity
    assign g_rnd = g_prod_reg + 50'sd8388608;
    assign g_sum = 26'($signed({1'b0, target_reg})) + $signed(g_rnd[49:24]);

    always_comb
    begin
        gain_next = lower_reg ? target_reg : g_sum[24:0];
        if (!need_reg && gain_next > RECOVERY_Q24)
        begin
            gain_next = UNITY_Q24;
        end
    end

    // apply gain, round and clamp
    assign y_rnd_l = y_prod_l_reg + 54'sd2147483648;
    assign y_rnd_r = y_prod_r_reg + 54'sd2147483648;
    assign y_l     = $signed(y_rnd_l[53:32]);
    assign y_r     = $signed(y_rnd_r[53:32]);

    always_comb
    begin
        if (y_l > 22'sd32767)
            clamp_l = 16'sd32767;
        else if (y_l < -22'sd32768)
            clamp_l = -16'sd32768;
        else
            clamp_l = 16'(y_l);
        if (y_r > 22'sd32767)
            clamp_r = 16'sd32767;
        else if (y_r < -22'sd32768)
            clamp_r = -16'sd32768;
        else
            clamp_r = 16'(y_r);
    end

    // control state: gain, divider count, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= UNITY_Q24;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.g2)
            begin
                gain_reg <= gain_next;
            end
            if (ctl.pk)
            begin
                cnt_reg <= '0;
            end
            else if (ctl.dv)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (ctl.o2 && !stat.out_stall)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (ctl.m1)
        begin
            p_ll_reg <= 43'(mix_ll) * 43'(mixed_left);
            p_lr_reg <= 43'(mix_lr) * 43'(mixed_right);
            p_rl_reg <= 43'(mix_rl) * 43'(mixed_left);
            p_rr_reg <= 43'(mix_rr) * 43'(mixed_right);
        end
        if (ctl.m2)
        begin
            ol_reg <= $signed(sum_l[43:16]);
            or_reg <= $signed(sum_r[43:16]);
        end
        if (ctl.pk)
        begin
            peak_reg <= peak_next;
            need_reg <= peak_next > FULL_SCALE_Q8;
            rem_reg  <= 29'd8388608;
            q_reg    <= '0;
        end
        else if (ctl.dv)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
        if (ctl.g1)
        begin
            target_reg <= target;
            lower_reg  <= target < gain_reg;
            g_prod_reg <= 50'(26'($signed({1'b0, gain_reg})) - 26'($signed({1'b0, target})))
                          * 50'($signed({1'b0, rel_coef}));
        end
        if (ctl.o1)
        begin
            y_prod_l_reg <= 54'(ol_reg) * 54'($signed({1'b0, gain_reg}));
            y_prod_r_reg <= 54'(or_reg) * 54'($signed({1'b0, gain_reg}));
        end
        if (ctl.o2 && !stat.out_stall)
        begin
            left_reg     <= clamp_l;
            right_reg    <= clamp_r;
            limiting_reg <= ~gain_reg[24];
        end
    end

    assign stat.div_need  = peak_next > FULL_SCALE_Q8;
    assign stat.div_done  = ctl.dv && (cnt_reg == CW'(DIV_STEPS - 1));
    assign stat.out_stall = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign left_out  = left_reg;
    assign right_out = right_reg;
    assign limiting  = limiting_reg;

endmodule

[hw/rtl/stereo_crossfeed_mix_limiter.sv]
// ----------------------------------------------------------------------------
// stereo_crossfeed_mix_limiter
// headphone crossfeed with 2x2 output matrix and peak limiter
//
//  channel  dir  payload                          transfer when
//  frame    in   left_in, right_in                valid && ready
//  result   out  left_out, right_out, limiting    valid && ready
//  cfg      in   index, data                      valid && ready (always ready)
//
// with crossfeed on, a frame runs the lowpass, history and delay steps; with
// crossfeed strength zero it skips them; the limiter divider (two quotient
// bits a cycle) runs only on frames whose peak exceeds full scale.
// one frame is in work at a time; the next is taken while a result waits.
// reset clears control state; history entries not yet written read as zero.
// a stalled result holds the sequencer in its last step.
// ----------------------------------------------------------------------------
`include "stereo_crossfeed_mix_limiter_assert.svh"

module stereo_crossfeed_mix_limiter
    import scf_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    scf_frame_if.sink    frame,
    scf_result_if.source result,
    scf_cfg_if.sink      cfg
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = AW + 3;

    typedef enum logic [16:0] {
        ST_IDLE = 17'b00000000000000001,
        ST_LP   = 17'b00000000000000010,
        ST_WR   = 17'b00000000000000100,
        ST_RA   = 17'b00000000000001000,
        ST_RB   = 17'b00000000000010000,
        ST_IP1  = 17'b00000000000100000,
        ST_IP2  = 17'b00000000001000000,
        ST_XF   = 17'b00000000010000000,
        ST_MX   = 17'b00000000100000000,
        ST_M1   = 17'b00000001000000000,
        ST_M2   = 17'b00000010000000000,
        ST_PK   = 17'b00000100000000000,
        ST_DV   = 17'b00001000000000000,
        ST_G1   = 17'b00010000000000000,
        ST_G2   = 17'b00100000000000000,
        ST_O1   = 17'b01000000000000000,
        ST_O2   = 17'b10000000000000000
    } scf_state_t;

    scf_state_t         state_reg, state_next;
    scf_ctl_t           ctl;
    scf_stat_t          stat;

    logic [14:0]        strength_reg;
    logic [15:0]        alpha_reg;
    logic [14:0]        delay_reg;
    logic [23:0]        rel_reg;
    logic signed [17:0] mix_ll_reg, mix_lr_reg, mix_rl_reg, mix_rr_reg;

    logic signed [15:0] pcm_l_reg, pcm_r_reg;
    logic [AW-1:0]      pos_reg;
    logic [AW:0]        fill_reg;
    logic [CW-1:0]      d_tmp;
    logic [AW-1:0]      d_mod;
    logic [AW:0]        a_sum;
    logic [AW-1:0]      tap_a, tap_b;
    logic               full;
    logic               ok_a, ok_b;
    logic signed [23:0] delayed_l, delayed_r;
    logic signed [24:0] mixed_l, mixed_r;
    logic               accept;

    assign accept      = frame.valid && frame.ready;
    assign frame.ready = (state_reg == ST_IDLE);
    assign cfg.ready   = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strength_reg <= STRENGTH_RST;
            alpha_reg    <= ALPHA_RST;
            delay_reg    <= DELAY_RST;
            rel_reg      <= REL_RST;
            mix_ll_reg   <= MIX_ONE_RST;
            mix_lr_reg   <= MIX_ZERO_RST;
            mix_rl_reg   <= MIX_ZERO_RST;
            mix_rr_reg   <= MIX_ONE_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (scf_reg_t'(cfg.index))
                REG_STRENGTH: strength_reg <= cfg.data[14:0];
                REG_ALPHA:    alpha_reg    <= cfg.data[15:0];
                REG_DELAY:    delay_reg    <= cfg.data[14:0];
                REG_RELEASE:  rel_reg      <= cfg.data[23:0];
                REG_MIX_LL:   mix_ll_reg   <= $signed(cfg.data[17:0]);
                REG_MIX_LR:   mix_lr_reg   <= $signed(cfg.data[17:0]);
                REG_MIX_RL:   mix_rl_reg   <= $signed(cfg.data[17:0]);
                REG_MIX_RR:   mix_rr_reg   <= $signed(cfg.data[17:0]);
                default:      strength_reg <= strength_reg;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (frame.valid) state_next = (strength_reg != '0) ? ST_LP : ST_XF;
            ST_LP:   state_next = ST_WR;
            ST_WR:   state_next = ST_RA;
            ST_RA:   state_next = ST_RB;
            ST_RB:   state_next = ST_IP1;
            ST_IP1:  state_next = ST_IP2;
            ST_IP2:  state_next = ST_XF;
            ST_XF:   state_next = ST_MX;
            ST_MX:   state_next = ST_M1;
            ST_M1:   state_next = ST_M2;
            ST_M2:   state_next = ST_PK;
            ST_PK:   state_next = stat.div_need ? ST_DV : ST_G1;
            ST_DV:   if (stat.div_done) state_next = ST_G1;
            ST_G1:   state_next = ST_G2;
            ST_G2:   state_next = ST_O1;
            ST_O1:   state_next = ST_O2;
            ST_O2:   if (!stat.out_stall) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // step strobes
    assign ctl.lp  = (state_reg == ST_LP);
    assign ctl.wr  = (state_reg == ST_WR);
    assign ctl.ra  = (state_reg == ST_RA);
    assign ctl.rb  = (state_reg == ST_RB);
    assign ctl.ip1 = (state_reg == ST_IP1);
    assign ctl.ip2 = (state_reg == ST_IP2);
    assign ctl.xf  = (state_reg == ST_XF);
    assign ctl.mx  = (state_reg == ST_MX);
    assign ctl.m1  = (state_reg == ST_M1);
    assign ctl.m2  = (state_reg == ST_M2);
    assign ctl.pk  = (state_reg == ST_PK);
    assign ctl.dv  = (state_reg == ST_DV);
    assign ctl.g1  = (state_reg == ST_G1);
    assign ctl.g2  = (state_reg == ST_G2);
    assign ctl.o1  = (state_reg == ST_O1);
    assign ctl.o2  = (state_reg == ST_O2);

    // input frame capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pcm_l_reg <= frame.left_in;
            pcm_r_reg <= frame.right_in;
        end
    end

    // write position and fill count of the history lines
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            fill_reg <= '0;
        end
        else if (ctl.ip1)
        begin
            pos_reg <= (pos_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : pos_reg + 1'b1;
            if (fill_reg != (AW + 1)'(HISTORY_DEPTH))
            begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    // integer delay modulo the history depth
    always_comb
    begin
        d_tmp = CW'(delay_reg[14:8]);
        for (int k = 2; k >= 0; k--)
        begin
            if (d_tmp >= CW'(HISTORY_DEPTH << k))
            begin
                d_tmp = d_tmp - CW'(HISTORY_DEPTH << k);
            end
        end
        d_mod = d_tmp[AW-1:0];
    end

    // tap addresses behind the write position
    always_comb
    begin
        a_sum = (AW + 1)'(pos_reg) + (AW + 1)'(HISTORY_DEPTH) - (AW + 1)'(d_mod);
        if (a_sum >= (AW + 1)'(HISTORY_DEPTH))
        begin
            a_sum = a_sum - (AW + 1)'(HISTORY_DEPTH);
        end
        tap_a = a_sum[AW-1:0];
        tap_b = (tap_a == '0) ? AW'(HISTORY_DEPTH - 1) : tap_a - 1'b1;
    end

    // entries at or below the write position have been written
    assign full = (fill_reg == (AW + 1)'(HISTORY_DEPTH));
    assign ok_a = full || (tap_a <= pos_reg);
    assign ok_b = full || (tap_b <= pos_reg);

    // channel lanes
    scf_lane #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_lane_l (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .pcm        (pcm_l_reg),
        .alpha      (alpha_reg),
        .frac       (delay_reg[7:0]),
        .strength   (strength_reg),
        .wr_addr    (pos_reg),
        .tap_a      (tap_a),
        .tap_b      (tap_b),
        .ok_a       (ok_a),
        .ok_b       (ok_b),
        .opp_delayed(delayed_r),
        .delayed    (delayed_l),
        .mixed      (mixed_l)
    );

    scf_lane #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_lane_r (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .pcm        (pcm_r_reg),
        .alpha      (alpha_reg),
        .frac       (delay_reg[7:0]),
        .strength   (strength_reg),
        .wr_addr    (pos_reg),
        .tap_a      (tap_a),
        .tap_b      (tap_b),
        .ok_a       (ok_a),
        .ok_b       (ok_b),
        .opp_delayed(delayed_l),
        .delayed    (delayed_r),
        .mixed      (mixed_r)
    );

    // matrix and limiter
    scf_limiter u_limiter (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .mixed_left (mixed_l),
        .mixed_right(mixed_r),
        .mix_ll     (mix_ll_reg),
        .mix_lr     (mix_lr_reg),
        .mix_rl     (mix_rl_reg),
        .mix_rr     (mix_rr_reg),
        .rel_coef   (rel_reg),
        .out_ready  (result.ready),
        .out_valid  (result.valid),
        .left_out   (result.left_out),
        .right_out  (result.right_out),
        .limiting   (result.limiting),
        .stat       (stat)
    );

    // checks
    `SCF_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= (AW + 1)'(HISTORY_DEPTH),
        "history fill count beyond depth")
    `SCF_ASSERT_IMP(a_pos_tracks_fill, !full, pos_reg == fill_reg[AW-1:0],
        "write position out of step with fill count")
    `SCF_ASSERT_NXT(a_bypass_skips_history, accept && (strength_reg == '0),
        state_reg == ST_XF, "bypass frame entered the history steps")

endmodule

[verif/scf_tb_if.sv]
// ----------------------------------------------------------------------------
// scf testbench channel notes
// the block's channel interfaces are reused as they are; this file only
// holds the result record the bench keeps for expected results
// ----------------------------------------------------------------------------
package scf_tb_pkg;

    // one expected result
    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
        logic               limiting;
    } scf_out_t;

endpackage

[verif/stereo_crossfeed_mix_limiter_tb.sv]
// ----------------------------------------------------------------------------
// stereo_crossfeed_mix_limiter_tb
// drives stereo frames and register writes with random idling on both sides,
// predicts each result with a bit-true crossfeed, matrix and limiter model,
// and checks every result in order, field by field
// ----------------------------------------------------------------------------
module stereo_crossfeed_mix_limiter_tb
    import scf_pkg::*, scf_tb_pkg::*;
();

    localparam int DEPTH      = 128;
    localparam int WATCHDOG   = 20000;
    localparam int DRAIN_WAIT = 60;

    logic clk;
    logic rst_n;

    scf_frame_if  frame ();
    scf_result_if result ();
    scf_cfg_if    cfg ();

    stereo_crossfeed_mix_limiter #(.HISTORY_DEPTH(DEPTH)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predictor state and registers
    longint strength, alpha, delay_q8, release_k, m_ll, m_lr, m_rl, m_rr;
    longint lp_l, lp_r, hist_l [DEPTH], hist_r [DEPTH];
    int     wpos;
    longint lim_gain;

    scf_out_t expected_q [$];
    int       mismatches;
    int       idle_cycles;
    bit       timed_out;
    bit       src_idle_en, snk_idle_en;
    int       hold_off;

    // rounding right shift, ties toward plus infinity
    function automatic longint round_shr(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint sx18(longint v);
        logic signed [17:0] t;
        t = v[17:0];
        return longint'(t);
    endfunction

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    task automatic model_reset();
        strength  = STRENGTH_RST;
        alpha     = ALPHA_RST;
        delay_q8  = DELAY_RST;
        release_k = REL_RST;
        m_ll      = 65536;
        m_lr      = 0;
        m_rl      = 0;
        m_rr      = 65536;
        lp_l      = 0;
        lp_r      = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            hist_l[i] = 0;
            hist_r[i] = 0;
        end
        wpos     = 0;
        lim_gain = 64'd16777216;
    endtask

    // crossfeed, matrix and limiter for one frame
    function automatic scf_out_t crossfeed_frame(logic signed [15:0] li,
                                                 logic signed [15:0] ri);
        longint xl, xr, a, b, ol, orr, peak, target, g, yl, yr, dl, dr, f;
        int d, ta, tb;
        scf_out_t r;
        xl = longint'(li) * 256;
        xr = longint'(ri) * 256;
        a  = xl;
        b  = xr;
        if (strength != 0)
        begin
            d    = int'((delay_q8 >> 8) % DEPTH);
            f    = delay_q8 & 255;
            lp_l = lp_l + round_shr(alpha * (xl - lp_l), 16);
            lp_r = lp_r + round_shr(alpha * (xr - lp_r), 16);
            hist_l[wpos] = lp_l;
            hist_r[wpos] = lp_r;
            ta = (wpos + DEPTH - d) % DEPTH;
            tb = (ta + DEPTH - 1) % DEPTH;
            dl = hist_l[ta] + round_shr(f * (hist_l[tb] - hist_l[ta]), 8);
            dr = hist_r[ta] + round_shr(f * (hist_r[tb] - hist_r[ta]), 8);
            wpos = (wpos + 1) % DEPTH;
            a = xl + round_shr(strength * dr, 16);
            b = xr + round_shr(strength * dl, 16);
        end
        ol   = round_shr(m_ll * a + m_lr * b, 16);
        orr  = round_shr(m_rl * a + m_rr * b, 16);
        peak = abs64(ol) > abs64(orr) ? abs64(ol) : abs64(orr);
        target = peak <= 8388608 ? 64'd16777216 : (longint'(1) << 47) / peak;
        g = lim_gain;
        if (target < g)
            g = target;
        else
            g = target + round_shr((g - target) * release_k, 24);
        if (target == 16777216 && g > 16775538)
            g = 16777216;
        lim_gain = g;
        yl = round_shr(ol * g, 32);
        yr = round_shr(orr * g, 32);
        if (yl > 32767) yl = 32767;
        if (yl < -32768) yl = -32768;
        if (yr > 32767) yr = 32767;
        if (yr < -32768) yr = -32768;
        r.left_out  = yl[15:0];
        r.right_out = yr[15:0];
        r.limiting  = g < 16777216;
        return r;
    endfunction

    // one frame transfer with optional leading idle burst
    // valid stays up after the transfer; the block drops ready until idle
    task automatic send_frame(logic signed [15:0] li, logic signed [15:0] ri);
        if (src_idle_en && $urandom_range(0, 3) == 0)
        begin
            frame.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        frame.valid    <= 1'b1;
        frame.left_in  <= li;
        frame.right_in <= ri;
        do
            @(posedge clk);
        while (!frame.ready);
        expected_q.push_back(crossfeed_frame(li, ri));
    endtask

    // register write, only while idle; caller drops valid after the last one
    task automatic write_reg(scf_reg_t idx, logic [23:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        case (idx)
            REG_STRENGTH: strength  = value[14:0];
            REG_ALPHA:    alpha     = value[15:0];
            REG_DELAY:    delay_q8  = value[14:0];
            REG_RELEASE:  release_k = value[23:0];
            REG_MIX_LL:   m_ll      = sx18(value[17:0]);
            REG_MIX_LR:   m_lr      = sx18(value[17:0]);
            REG_MIX_RL:   m_rl      = sx18(value[17:0]);
            default:      m_rr      = sx18(value[17:0]);
        endcase
    endtask

    task automatic wait_drained();
        frame.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_setting(int s, int dly, int rel,
                                 int ll, int lr, int rl, int rr, int lpc);
        wait_drained();
        write_reg(REG_STRENGTH, 24'(s));
        write_reg(REG_ALPHA, 24'(lpc));
        write_reg(REG_DELAY, 24'(dly));
        write_reg(REG_RELEASE, 24'(rel));
        write_reg(REG_MIX_LL, 24'(ll));
        write_reg(REG_MIX_LR, 24'(lr));
        write_reg(REG_MIX_RL, 24'(rl));
        write_reg(REG_MIX_RR, 24'(rr));
        cfg.valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'($urandom_range(0, 15)) - 16'sd8;
            default: return 16'($urandom());
        endcase
    endfunction

    // directed extremes in bypass, then crossfeed
    task automatic test_directed();
        logic signed [15:0] vals [6] = '{16'sh7fff, 16'sh8000, 0, 1, -1, 16'sh5555};
        foreach (vals[i])
            send_frame(vals[i], vals[5 - i]);
        write_setting(26214, 300, 16770227, 131071, -131072, -131072, 131071, 65535);
        foreach (vals[i])
            send_frame(vals[i], vals[i]);
        // largest delay; the tap addresses wrap around the history
        write_setting(26214, 32767, 0, 65536, 0, 0, 65536, 1);
        for (int i = 0; i < 6; i++)
            send_frame(vals[i], -vals[i]);
        // limiter recovery with slow release
        write_setting(0, 0, 16777215, 131071, 131071, 131071, 131071, 5738);
        send_frame(16'sh7fff, 16'sh7fff);
        send_frame(16'sh8000, 16'sh8000);
        send_frame(100, 100);
        send_frame(0, 0);
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
            send_frame(rand_sample(), rand_sample());
    endtask

    // several random settings including extremes
    task automatic test_random_settings();
        for (int p = 0; p < 8; p++)
        begin
            write_setting($urandom_range(0, 1) ? $urandom_range(1, 26214) : 0,
                          $urandom_range(0, 32767),
                          $urandom_range(0, 1) ? $urandom_range(16000000, 16777215)
                                               : $urandom_range(0, 16777215),
                          $urandom_range(0, 262143) - 131072,
                          $urandom_range(0, 262143) - 131072,
                          $urandom_range(0, 262143) - 131072,
                          $urandom_range(0, 262143) - 131072,
                          $urandom_range(1, 65535));
            run_random(140);
        end
    endtask

    // receiver holds off long while frames keep coming
    task automatic test_backpressure();
        write_setting(13107, 1000, 16770227, 40000, 20000, 20000, 40000, 5738);
        // set between edges so the receiver's own update cannot overwrite it
        @(negedge clk);
        hold_off = 300;
        @(posedge clk);
        run_random(60);
    endtask

    // last part with no idling on either side
    task automatic test_streaming();
        write_setting(26214, 384, 16770227, 65536, 0, 0, 65536, 5738);
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        run_random(150);
    endtask

    // result receiver with idle bursts and long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
        end
        else if (hold_off > 0)
        begin
            hold_off     <= hold_off - 1;
            result.ready <= 1'b0;
        end
        else if (snk_idle_en && result.ready && $urandom_range(0, 7) == 0)
        begin
            hold_off     <= $urandom_range(1, 10);
            result.ready <= 1'b0;
        end
        else
        begin
            result.ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        scf_out_t exp_r;
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result L=%0d R=%0d lim=%0b",
                             result.left_out, result.right_out, result.limiting);
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (exp_r.left_out !== result.left_out || exp_r.right_out !== result.right_out
                    || exp_r.limiting !== result.limiting)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp L=%0d R=%0d lim=%0b got L=%0d R=%0d lim=%0b",
                                 exp_r.left_out, exp_r.right_out, exp_r.limiting,
                                 result.left_out, result.right_out, result.limiting);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((frame.valid && frame.ready) || (result.valid && result.ready)
            || (cfg.valid && cfg.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG && !timed_out)
        begin
            timed_out = 1'b1;
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        mismatches     = 0;
        idle_cycles    = 0;
        timed_out      = 1'b0;
        hold_off       = 0;
        src_idle_en    = 1'b1;
        snk_idle_en    = 1'b1;
        rst_n          = 1'b0;
        frame.valid    = 1'b0;
        frame.left_in  = '0;
        frame.right_in = '0;
        cfg.valid      = 1'b0;
        cfg.index      = REG_STRENGTH;
        cfg.data       = '0;
        model_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_settings();
        test_backpressure();
        test_streaming();
        wait_drained();

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
